/* sv/srj_pkg.sv */
// sorted range join: shared types and constants
// sequencer states, command codes and field widths
// no dependencies
`default_nettype none

package srj_pkg;

    // field widths
    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CMD_W = 2;

    // one stored row: payload, upper, lower from the top bit down
    localparam int unsigned ROW_W = 3 * KEY_W;

    // result for a probe past the last row in index mode
    localparam logic [VAL_W-1:0] PAST_END_INDEX = '1;

    // command codes carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_PROBE  = 2'd1,
        CMD_REWIND = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // probe sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_ZRD,
        ST_ZDAT,
        ST_OUT
    } state_t;

    // one stored row
    typedef struct packed {
        logic [KEY_W-1:0] payload;
        logic [KEY_W-1:0] upper;
        logic [KEY_W-1:0] lower;
    } row_t;

endpackage

`default_nettype wire

/* sv/sorted_range_join_top.sv */
// sorted range join: top level, merge scan of ascending probes over a row table
// depends on srj_pkg and srj_ram
//
// channel   dir  signals                        contents (lowest bit up)
// s_*       in   s_tvalid s_tready s_tdata      lower_bound, upper_bound, payload,
//                s_tuser                        search_value; tuser: command
// m_*       out  m_tvalid m_tready m_tdata      match_value; tuser: found
//                m_tuser
// cfg_*     in   cfg_we cfg_wdata               use_from_value
//
// a probe reads the row at the scan pointer and compares it, then reads and
// compares the next row for each row the scan pointer skips, until a hit,
// a row starting above the key or a skip past the last row (no compare at
// all when the pointer already sits past it); a probe below the current row
// in payload mode rereads row 0; each step is one ram read and a compare
// reset clears row count, scan pointer and the sequencer; ram needs no clear
// the input stalls while a probe is in flight; a finished result waits in
// the output register and new words are taken meanwhile
`default_nettype none

module sorted_range_join_top #(
    parameter int ROWS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [4*srj_pkg::KEY_W-1:0] s_tdata,  // lower, upper, payload, search
    input  wire logic [srj_pkg::CMD_W-1:0]  s_tuser,   // command
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [srj_pkg::VAL_W-1:0]       m_tdata,   // match_value
    output logic [0:0]                      m_tuser,   // found
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_wdata
);

    import srj_pkg::*;

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(ROWS + 1);

    state_t           state_reg,     state_next;
    logic [CW-1:0]    count_reg,     count_next;
    logic [CW-1:0]    ptr_reg,       ptr_next;
    logic [KEY_W-1:0] key_reg,       key_next;
    logic [VAL_W-1:0] res_value_reg, res_value_next;
    logic             res_found_reg, res_found_next;
    logic             ufv_reg;
    logic             m_tvalid_reg,  m_tvalid_next;
    logic [VAL_W-1:0] m_tdata_reg,   m_tdata_next;
    logic             m_found_reg,   m_found_next;

    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    row_t             ram_wrow;
    row_t             ram_rrow;
    logic             lo_le_key;
    logic             key_le_hi;
    logic [CW:0]      ptr_inc;
    cmd_t             cmd;

    assign cmd = cmd_t'(s_tuser);

    // row storage
    assign ram_wrow = '{payload: s_tdata[3*KEY_W-1:2*KEY_W],
                        upper:   s_tdata[2*KEY_W-1:KEY_W],
                        lower:   s_tdata[KEY_W-1:0]};

    srj_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wrow),
        .raddr (ram_raddr),
        .rdata (ram_rrow)
    );

    // shared signed compare against the row just read
    assign lo_le_key = $signed(ram_rrow.lower) <= $signed(key_reg);
    assign key_le_hi = $signed(key_reg) <= $signed(ram_rrow.upper);
    assign ptr_inc   = {1'b0, ptr_reg} + {{CW{1'b0}}, 1'b1};

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ufv_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            ufv_reg <= cfg_wdata;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        m_tdata_reg   <= m_tdata_next;
        m_found_reg   <= m_found_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        key_next       = key_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        m_tdata_next   = m_tdata_reg;
        m_found_next   = m_found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_raddr      = ptr_reg[AW-1:0];
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            // rows beyond capacity are dropped
                            if (count_reg < CW'(ROWS))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_PROBE:
                        begin
                            // read of the row at the pointer is issued now
                            key_next = s_tdata[4*KEY_W-1:3*KEY_W];
                            if (ptr_reg < count_reg)
                            begin
                                state_next = ST_CMP;
                            end
                            else
                            begin
                                res_value_next = ufv_reg ? '0 : PAST_END_INDEX;
                                res_found_next = 1'b0;
                                state_next     = ST_OUT;
                            end
                        end
                        CMD_REWIND:
                        begin
                            ptr_next = '0;
                        end
                        CMD_CLEAR:
                        begin
                            ptr_next   = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!lo_le_key)
                begin
                    // probe below the current row
                    if (ufv_reg)
                    begin
                        state_next = ST_ZRD;
                    end
                    else
                    begin
                        res_value_next = '0;
                        res_found_next = 1'b0;
                        state_next     = ST_OUT;
                    end
                end
                else if (key_le_hi)
                begin
                    // hit
                    res_value_next = ufv_reg ? ram_rrow.payload : VAL_W'(ptr_reg);
                    res_found_next = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    // skip this row
                    ptr_next = ptr_inc[CW-1:0];
                    if (ptr_inc < {1'b0, count_reg})
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        res_value_next = ufv_reg ? '0 : PAST_END_INDEX;
                        res_found_next = 1'b0;
                        state_next     = ST_OUT;
                    end
                end
            end
            ST_ZRD:
            begin
                ram_raddr  = '0;
                state_next = ST_ZDAT;
            end
            ST_ZDAT:
            begin
                res_value_next = ram_rrow.payload;
                res_found_next = 1'b0;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = res_value_reg;
                    m_found_next  = res_found_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_found_reg;

    // scan pointer stays at or below the row count
    a_ptr_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("scan pointer beyond row count");

    // row count stays within capacity
    a_count_le_rows: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ROWS))
        else $error("row count beyond capacity");

    // a compare only looks at a loaded row
    a_cmp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (ptr_reg < count_reg))
        else $error("compare on an unloaded row");

    // a new result only comes from the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result presented outside output state");

    // table holds while a probe is in flight
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("row count changed during a probe");

endmodule

`default_nettype wire

/* sv/srj_ram.sv */
// sorted range join: generic single-port-write, single-port-read ram
// registered read data, contents undefined until written
// no dependencies
`default_nettype none

module srj_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sim/tb_sorted_range_join_top.sv */
// testbench for sorted_range_join_top: directed table, random load and probe episodes, a full table
// checks each result word against the directed table's typed results or an in-bench merge scan predictor
// depends on srj_pkg and the sorted_range_join_top rtl
`default_nettype none

module tb_sorted_range_join_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srj_pkg::*;

    localparam int ROWS = 1024;
    localparam int TAIL_CYCLES = 8;
    localparam int KEY_MIN = -2147483647 - 1;
    localparam int KEY_MAX = 2147483647;

    // one result word: match value and found flag
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             found;
    } match_t;

    // one row of the directed table, with typed results for both modes
    typedef struct {
        cmd_t cmd;
        int   lower;
        int   upper;
        int   payload;
        int   search;
        bit   typed;
        int   index_value;
        bit   index_found;
        int   payload_value;
        bit   payload_found;
    } step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [4*KEY_W-1:0]     s_tdata;   // lower, upper, payload, search
    logic [CMD_W-1:0]       s_tuser;   // command
    logic                   m_tvalid;
    logic                   m_tready;
    logic [VAL_W-1:0]       m_tdata;   // match_value
    logic [0:0]             m_tuser;   // found
    logic                   cfg_we;
    logic                   cfg_wdata;

    // predictor state: row table, scan pointer and result mode
    int     row_lower [ROWS];
    int     row_upper [ROWS];
    int     row_payload [ROWS];
    int     rows_held = 0;
    int     scan_pos = 0;
    bit     payload_mode = 1'b0;

    match_t pending_matches [$];
    int     words_sent = 0;
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    step_t  directed_steps [14] = '{
        '{CMD_PROBE,  0,       0,    0,            0,       1, -1, 0, 0,            0},
        '{CMD_LOAD,   KEY_MIN, -100, KEY_MAX,      0,       0, 0,  0, 0,            0},
        '{CMD_LOAD,   -50,     50,   KEY_MIN,      0,       0, 0,  0, 0,            0},
        '{CMD_LOAD,   100,     1000, 32'h12345678, 0,       0, 0,  0, 0,            0},
        '{CMD_PROBE,  0,       0,    0,            KEY_MIN, 1, 0,  1, KEY_MAX,      1},
        '{CMD_PROBE,  0,       0,    0,            -75,     1, 0,  0, KEY_MAX,      0},
        '{CMD_PROBE,  0,       0,    0,            50,      1, 1,  1, KEY_MIN,      1},
        '{CMD_PROBE,  0,       0,    0,            75,      1, 0,  0, KEY_MAX,      0},
        '{CMD_PROBE,  0,       0,    0,            1000,    1, 2,  1, 32'h12345678, 1},
        '{CMD_PROBE,  0,       0,    0,            KEY_MAX, 1, -1, 0, 0,            0},
        '{CMD_REWIND, 0,       0,    0,            0,       0, 0,  0, 0,            0},
        '{CMD_PROBE,  0,       0,    0,            0,       1, 1,  1, KEY_MIN,      1},
        '{CMD_CLEAR,  0,       0,    0,            0,       0, 0,  0, 0,            0},
        '{CMD_PROBE,  0,       0,    0,            5,       1, -1, 0, 0,            0}
    };

    sorted_range_join_top #(
        .ROWS(ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // merge scan of one command word; returns 1 when it yields a result word
    function automatic bit join_lookup(input cmd_t cmd, input int lower, input int upper,
                                       input int payload, input int search,
                                       output match_t result);
        result.value = payload_mode ? '0 : PAST_END_INDEX;
        result.found = 1'b0;
        case (cmd)
            CMD_LOAD:
            begin
                // a full table drops the row
                if (rows_held < ROWS)
                begin
                    row_lower[rows_held] = lower;
                    row_upper[rows_held] = upper;
                    row_payload[rows_held] = payload;
                    rows_held++;
                end
                return 1'b0;
            end
            CMD_REWIND:
            begin
                scan_pos = 0;
                return 1'b0;
            end
            CMD_CLEAR:
            begin
                rows_held = 0;
                scan_pos = 0;
                return 1'b0;
            end
            default: ;
        endcase
        // probe: skip rows ending below the key, stop at a hit or a row starting above it
        while (scan_pos < rows_held)
        begin
            if (row_lower[scan_pos] > search)
            begin
                if (payload_mode)
                    result.value = row_payload[0];
                else
                    result.value = '0;
                break;
            end
            if (search <= row_upper[scan_pos])
            begin
                if (payload_mode)
                    result.value = row_payload[scan_pos];
                else
                    result.value = scan_pos;
                result.found = 1'b1;
                break;
            end
            scan_pos++;
        end
        return 1'b1;
    endfunction

    // present one word, wait for the handshake, then record what it should produce
    task automatic send_word(input cmd_t cmd, input int lower, input int upper,
                             input int payload, input int search,
                             input bit typed = 1'b0, input match_t typed_result = '0);
        match_t predicted;
        bit     gives;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {search, payload, upper, lower};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gives = join_lookup(cmd, lower, upper, payload, search, predicted);
        if (gives)
            pending_matches.push_back(typed ? typed_result : predicted);
        words_sent++;
    endtask

    // stop sending and wait until every result word has come back
    task automatic drain_results(input int tail);
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // write the result mode register while the block is idle
    task automatic set_mode(input bit mode);
        drain_results(TAIL_CYCLES);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        payload_mode = mode;
        @(posedge clk);
    endtask

    // key spread: full range, or narrow windows around zero so ranges meet
    function automatic int pick_key();
        case ($urandom_range(2))
            0: return int'($urandom);
            1: return int'($urandom_range(4000)) - 2000;
            default: return int'($urandom_range(200)) - 100;
        endcase
    endfunction

    task automatic run_directed();
        match_t typed_result;
        foreach (directed_steps[i])
        begin
            if (payload_mode)
            begin
                typed_result.value = directed_steps[i].payload_value;
                typed_result.found = directed_steps[i].payload_found;
            end
            else
            begin
                typed_result.value = directed_steps[i].index_value;
                typed_result.found = directed_steps[i].index_found;
            end
            send_word(directed_steps[i].cmd, directed_steps[i].lower, directed_steps[i].upper,
                      directed_steps[i].payload, directed_steps[i].search,
                      directed_steps[i].typed, typed_result);
        end
    endtask

    // clear, load rows with sorted bounds, then ascending probes, sometimes rescanned
    task automatic run_episode();
        int     n_rows;
        int     n_probes;
        int     pick;
        longint width;
        int     bounds [$];
        int     keys [$];
        n_rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        n_probes = $urandom_range(1, 10);
        for (int i = 0; i < 2 * n_rows; i++)
            bounds.push_back(pick_key());
        bounds.sort();
        for (int j = 0; j < n_probes; j++)
        begin
            if (n_rows > 0 && $urandom_range(1) == 1)
            begin
                pick = $urandom_range(n_rows - 1);
                width = longint'(bounds[2*pick+1]) - longint'(bounds[2*pick]) + 1;
                keys.push_back(int'(longint'(bounds[2*pick]) + longint'($urandom) % width));
            end
            else
                keys.push_back(pick_key());
        end
        keys.sort();
        send_word(CMD_CLEAR, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        for (int i = 0; i < n_rows; i++)
            send_word(CMD_LOAD, bounds[2*i], bounds[2*i+1], int'($urandom), int'($urandom));
        foreach (keys[j])
            send_word(CMD_PROBE, int'($urandom), int'($urandom), int'($urandom), keys[j]);
        if ($urandom_range(2) == 0)
        begin
            send_word(CMD_REWIND, int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom));
            foreach (keys[j])
                send_word(CMD_PROBE, int'($urandom), int'($urandom), int'($urandom), keys[j]);
        end
    endtask

    // mostly well-formed episodes, some raw words, and an occasional full drain
    task automatic run_random(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(29) == 0)
                drain_results(TAIL_CYCLES);
            if ($urandom_range(99) < 15)
                send_word(cmd_t'($urandom_range(3)), int'($urandom), int'($urandom),
                          int'($urandom), int'($urandom));
            else
                run_episode();
        end
    endtask

    // fill the table past its size, probe across it, then rescan to the last row
    task automatic run_full_table();
        int base_key;
        int rows_picked [$];
        base_key = -100000;
        send_word(CMD_CLEAR, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        for (int i = 0; i < ROWS + 2; i++)
            send_word(CMD_LOAD, base_key + 16 * i, base_key + 16 * i + 7, int'($urandom),
                      int'($urandom));
        for (int j = 0; j < 12; j++)
            rows_picked.push_back($urandom_range(ROWS - 1));
        rows_picked.push_back(ROWS - 1);
        rows_picked.sort();
        // keys inside a row or in the gap after it
        foreach (rows_picked[j])
            send_word(CMD_PROBE, int'($urandom), int'($urandom), int'($urandom),
                      base_key + 16 * rows_picked[j] + $urandom_range(15));
        // would hit a dropped row, so past the end
        send_word(CMD_PROBE, int'($urandom), int'($urandom), int'($urandom),
                  base_key + 16 * ROWS + 3);
        send_word(CMD_REWIND, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        send_word(CMD_PROBE, int'($urandom), int'($urandom), int'($urandom),
                  base_key + 16 * (ROWS - 1));
        send_word(CMD_PROBE, int'($urandom), int'($urandom), int'($urandom), KEY_MAX);
    endtask

    // result side: random backpressure and in-order compare
    initial
    begin
        match_t expected_match;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_matches.size() == 0)
                begin
                    $error("result word with no probe waiting: match_value %0d found %0d",
                           $signed(m_tdata), m_tuser[0]);
                    fail_count++;
                end
                else
                begin
                    expected_match = pending_matches.pop_front();
                    if (m_tdata !== expected_match.value)
                    begin
                        $error("match_value: expected %0d, actual %0d",
                               $signed(expected_match.value), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser[0] !== expected_match.found)
                    begin
                        $error("found: expected %0d, actual %0d",
                               expected_match.found, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stimulus sequence
    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_LOAD;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow receiver
        send_idle_pct = 11;
        recv_idle_pct = 81;
        run_directed();
        set_mode(1'b1);
        run_directed();
        set_mode(1'b0);
        run_random(80);

        // slow sender
        drain_results(TAIL_CYCLES);
        send_idle_pct = 81;
        recv_idle_pct = 11;
        set_mode(1'b1);
        run_random(90);

        // full rate
        drain_results(TAIL_CYCLES);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_mode(1'b0);
        run_full_table();
        set_mode(1'b1);
        run_random(80);

        drain_results(2 * TAIL_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sorted_range_join_top.f */
sv/srj_pkg.sv
sv/srj_ram.sv
sv/sorted_range_join_top.sv
sim/tb_sorted_range_join_top.sv
